/* rtl/core/hslp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_pkg
// Shared types and constants for the linear-probe hash set: transfer
// structs, status codes, hash constants and controller/datapath commands.
// ----------------------------------------------------------------------------
package hslp_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_W        = 64;
  localparam int VAL_W        = 8;
  localparam int CNT_W        = 11;

  // splitmix64 finalizer constants
  localparam logic [KEY_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d0_49bb_1331_11eb;
  localparam int SHR_PRE = 30;
  localparam int SHR_MID = 27;
  localparam int SHR_FIN = 31;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_PRESENT  = 3'd1,
    STAT_FOUND    = 3'd2,
    STAT_ABSENT   = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_BAD_KEY  = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_FIND   = 1'b1
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    sel;
    logic    respond;
    logic    insert;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_key;
    logic is_find;
    logic slot_empty;
    logic slot_match;
    logic probe_last;
    logic clear_last;
  } dp_stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_READ,
    S_CHECK
  } ctl_state_t;

endpackage

/* rtl/core/hslp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_datapath
// Hash unit with one shared 32x32 multiplier, probe address and counters,
// key and value memories, entry count, mode register and result register.
// ----------------------------------------------------------------------------
module hslp_datapath #(
  parameter int CAPACITY = hslp_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hslp_pkg::req_t    req,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  hslp_pkg::dp_cmd_t cmd,
  output hslp_pkg::dp_stat_t stat,
  output hslp_pkg::rsp_t    rsp,
  output logic              done
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  hslp_pkg::req_t item;
  logic [hslp_pkg::KEY_W-1:0] stored;
  logic [hslp_pkg::KEY_W-1:0] hv;
  logic [hslp_pkg::KEY_W-1:0] acc;
  logic [hslp_pkg::KEY_W-1:0] prod;
  logic [AW-1:0]              pos;
  logic [AW-1:0]              probes;
  logic [hslp_pkg::KEY_W-1:0] q_key;
  logic [hslp_pkg::VAL_W-1:0] q_val;
  logic [hslp_pkg::CNT_W-1:0] key_count;
  logic                       keep_values;

  logic [hslp_pkg::KEY_W-1:0] kmem [CAPACITY];
  logic [hslp_pkg::VAL_W-1:0] vmem [CAPACITY];

  logic [hslp_pkg::KEY_W-1:0] seed;
  logic [hslp_pkg::KEY_W-1:0] mix_const;
  logic [31:0]                mul_a;
  logic [31:0]                mul_c;
  logic [hslp_pkg::KEY_W-1:0] mul_res;
  logic [hslp_pkg::KEY_W-1:0] mixed;
  logic [31:0]                res_hi;
  logic                       key_we;
  logic [hslp_pkg::KEY_W-1:0] key_wd;
  logic [hslp_pkg::CNT_W-1:0] count_inc;

  assign seed      = req.key + hslp_pkg::GOLDEN;
  assign mix_const = cmd.sel ? hslp_pkg::MIX_C2 : hslp_pkg::MIX_C1;
  assign mul_a     = (cmd.op == hslp_pkg::OP_MUL2) ? hv[63:32] : hv[31:0];
  assign mul_c     = (cmd.op == hslp_pkg::OP_MUL1) ? mix_const[63:32] : mix_const[31:0];
  // low 64 bits of the product: lo*lo plus both cross terms shifted up
  assign res_hi    = acc[63:32] + prod[31:0];
  assign mul_res   = {res_hi, acc[31:0]};
  assign mixed     = cmd.sel ? (mul_res ^ (mul_res >> hslp_pkg::SHR_FIN))
                             : (mul_res ^ (mul_res >> hslp_pkg::SHR_MID));
  assign count_inc = key_count + hslp_pkg::CNT_W'(1);

  assign key_we = (cmd.op == hslp_pkg::OP_CLEAR) || cmd.insert;
  assign key_wd = cmd.insert ? stored : '0;

  // hash and operand registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      hslp_pkg::OP_LOAD: begin
        item   <= req;
        stored <= req.key + hslp_pkg::KEY_W'(1);
        hv     <= seed ^ (seed >> hslp_pkg::SHR_PRE);
      end
      hslp_pkg::OP_MUL0: begin
        prod <= hslp_pkg::KEY_W'(mul_a) * hslp_pkg::KEY_W'(mul_c);
      end
      hslp_pkg::OP_MUL1: begin
        acc  <= prod;
        prod <= hslp_pkg::KEY_W'(mul_a) * hslp_pkg::KEY_W'(mul_c);
      end
      hslp_pkg::OP_MUL2: begin
        acc[63:32] <= res_hi;
        prod       <= hslp_pkg::KEY_W'(mul_a) * hslp_pkg::KEY_W'(mul_c);
      end
      hslp_pkg::OP_MUL3: begin
        hv <= mixed;
      end
      default: begin
      end
    endcase
  end

  // probe address, counters and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      probes      <= '0;
      key_count   <= '0;
      keep_values <= 1'b1;
      done        <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (cfg_we) begin
        keep_values <= cfg_wdata;
      end
      if (cmd.insert) begin
        key_count <= count_inc;
      end
      unique case (cmd.op)
        hslp_pkg::OP_CLEAR: begin
          pos <= pos + AW'(1);
        end
        hslp_pkg::OP_MUL3: begin
          if (cmd.sel) begin
            pos    <= mixed[AW-1:0];
            probes <= '0;
          end
        end
        hslp_pkg::OP_NEXT: begin
          pos    <= pos + AW'(1);
          probes <= probes + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // slot memories, registered read at the probe address
  always_ff @(posedge clk) begin
    if (key_we) begin
      kmem[pos] <= key_wd;
    end
    q_key <= kmem[pos];
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && keep_values) begin
      vmem[pos] <= item.entry_value;
    end
    q_val <= vmem[pos];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      rsp.status      <= cmd.code;
      rsp.found_value <= ((cmd.code == hslp_pkg::STAT_FOUND) && keep_values) ? q_val : '0;
      rsp.entry_count <= cmd.insert ? count_inc : key_count;
    end
  end

  always_comb begin
    stat.bad_key    = &item.key;
    stat.is_find    = (item.func == hslp_pkg::FUNC_FIND);
    stat.slot_empty = (q_key == '0);
    stat.slot_match = (q_key == stored);
    stat.probe_last = (probes == LAST_SLOT);
    stat.clear_last = (pos == LAST_SLOT);
  end

endmodule

/* rtl/core/hslp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_ctrl
// Sequencer: clearing pass, two hash multiply rounds, probe read/check loop
// and the result decision.
// ----------------------------------------------------------------------------
module hslp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  hslp_pkg::dp_stat_t stat,
  output hslp_pkg::dp_cmd_t  cmd
);

  hslp_pkg::ctl_state_t state;
  hslp_pkg::ctl_state_t state_next;
  logic                 round;
  logic                 round_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hslp_pkg::S_CLEAR;
      round <= 1'b0;
    end else begin
      state <= state_next;
      round <= round_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    round_next = round;
    unique case (state)
      hslp_pkg::S_CLEAR: begin
        if (stat.clear_last) begin
          state_next = hslp_pkg::S_IDLE;
        end
      end
      hslp_pkg::S_IDLE: begin
        if (start) begin
          state_next = hslp_pkg::S_MUL0;
          round_next = 1'b0;
        end
      end
      hslp_pkg::S_MUL0: begin
        if (!round && stat.bad_key) begin
          state_next = hslp_pkg::S_IDLE;
        end else begin
          state_next = hslp_pkg::S_MUL1;
        end
      end
      hslp_pkg::S_MUL1: state_next = hslp_pkg::S_MUL2;
      hslp_pkg::S_MUL2: state_next = hslp_pkg::S_MUL3;
      hslp_pkg::S_MUL3: begin
        state_next = round ? hslp_pkg::S_READ : hslp_pkg::S_MUL0;
        round_next = 1'b1;
      end
      hslp_pkg::S_READ: state_next = hslp_pkg::S_CHECK;
      hslp_pkg::S_CHECK: begin
        if (stat.slot_empty || stat.slot_match || stat.probe_last) begin
          state_next = hslp_pkg::S_IDLE;
        end else begin
          state_next = hslp_pkg::S_READ;
        end
      end
      default: state_next = hslp_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = (state != hslp_pkg::S_IDLE);
    cmd.op      = hslp_pkg::OP_NONE;
    cmd.sel     = round;
    cmd.respond = 1'b0;
    cmd.insert  = 1'b0;
    cmd.code    = hslp_pkg::STAT_FULL;
    unique case (state)
      hslp_pkg::S_CLEAR: cmd.op = hslp_pkg::OP_CLEAR;
      hslp_pkg::S_IDLE: begin
        if (start) begin
          cmd.op = hslp_pkg::OP_LOAD;
        end
      end
      hslp_pkg::S_MUL0: begin
        if (!round && stat.bad_key) begin
          cmd.respond = 1'b1;
          cmd.code    = hslp_pkg::STAT_BAD_KEY;
        end else begin
          cmd.op = hslp_pkg::OP_MUL0;
        end
      end
      hslp_pkg::S_MUL1: cmd.op = hslp_pkg::OP_MUL1;
      hslp_pkg::S_MUL2: cmd.op = hslp_pkg::OP_MUL2;
      hslp_pkg::S_MUL3: cmd.op = hslp_pkg::OP_MUL3;
      hslp_pkg::S_READ: cmd.op = hslp_pkg::OP_NONE;
      hslp_pkg::S_CHECK: begin
        priority if (stat.slot_empty) begin
          cmd.respond = 1'b1;
          cmd.insert  = !stat.is_find;
          cmd.code    = stat.is_find ? hslp_pkg::STAT_ABSENT : hslp_pkg::STAT_INSERTED;
        end else if (stat.slot_match) begin
          cmd.respond = 1'b1;
          cmd.code    = stat.is_find ? hslp_pkg::STAT_FOUND : hslp_pkg::STAT_PRESENT;
        end else if (stat.probe_last) begin
          // wrapped all the way round without an empty slot or a match
          cmd.respond = 1'b1;
          cmd.code    = hslp_pkg::STAT_FULL;
        end else begin
          cmd.op = hslp_pkg::OP_NEXT;
        end
      end
      default: cmd.op = hslp_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/core/hash_set_linear_probe_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_set_linear_probe_unit
// Open-addressing hash set with linear probing and a splitmix64 home slot.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the key memory with busy
// high. An operation is taken when start is high and busy is low; its result
// appears on rsp for one cycle with done high and cannot be held off. A
// normal operation keeps busy high through the hash and through each slot
// probed, up to CAPACITY slots when the table is full: the hash uses one
// 32x32 multiplier for two 64-bit products, each in states MUL0 to MUL3,
// and each probe is one registered read of the single-port key memory
// followed by a compare. done is high in the first cycle with busy low, and
// the next start is taken in that same cycle. An all-ones key gets bad key
// from state MUL0. keep_values is to be written through cfg_we and cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module hash_set_linear_probe_unit #(
  parameter int CAPACITY = hslp_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  hslp_pkg::req_t req,
  output logic           done,
  output hslp_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  hslp_pkg::dp_cmd_t  cmd;
  hslp_pkg::dp_stat_t stat;

  hslp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  hslp_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp),
    .done      (done)
  );

endmodule

/* rtl/core/hslp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_checker
// Port-level checks for the hash set: start/busy/done sequencing and
// result field consistency.
// ----------------------------------------------------------------------------
module hslp_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input hslp_pkg::rsp_t rsp
);

  // an accepted transfer keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted operation did not raise busy");

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding busy cycle");

  // the block is ready again when its result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while result is shown");

  a_value_only_found: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != hslp_pkg::STAT_FOUND)) |-> (rsp.found_value == '0))
    else $error("found_value set for a result that is not found");

endmodule

bind hash_set_linear_probe_unit hslp_checker u_hslp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
